@@ rtl/core/stick_rate_expo_shaper_macros.svh @@
// ----------------------------------------------------------------------------
// Stick rate expo shaper assertion macros
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef STICK_RATE_EXPO_SHAPER_MACROS_SVH
`define STICK_RATE_EXPO_SHAPER_MACROS_SVH

// Plain property check
`define SRX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication check: cons must follow whenever ante holds
`define SRX_ASSERT_IMP(lbl, ante, cons, msg) \
	`SRX_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ rtl/core/srx_pkg.sv @@
// ----------------------------------------------------------------------------
// srx_pkg
// Types, widths and constants shared by the stick rate expo shaper modules.
// ----------------------------------------------------------------------------
package srx_pkg;

	// Stick format: signed, FRAC_BITS fraction bits
	localparam int STICK_BITS = 16;
	localparam int FRAC_BITS  = STICK_BITS - 1;
	localparam int MAG_W      = STICK_BITS;

	// Axis path fixed point: Q24 unsigned magnitudes
	localparam int QF      = 24;
	localparam int Q_W     = QF + 1;
	localparam int A_SHIFT = QF - FRAC_BITS;
	localparam int FLD_W   = 8;
	localparam int LIMF_W  = 16;
	localparam int AC_W    = Q_W + FLD_W;
	localparam int SQD_W   = Q_W + FLD_W;
	localparam int N_W     = 32;
	localparam int EM_W    = 26;
	localparam int G_W     = 28;
	localparam int U_W     = 60;
	localparam int UM_W    = U_W - 1;
	localparam int P5_W    = UM_W + 3;
	localparam int RND_SH  = 43;

	// Expo percent division by a reciprocal, exact for a 32-bit dividend
	localparam int PCT_DIV  = 100;
	localparam int EM_BIAS  = 50;
	localparam int DIV100_K = 38;
	localparam logic [31:0] DIV100_R =
		32'(((64'd1 << DIV100_K) + 64'(PCT_DIV) - 64'd1) / 64'(PCT_DIV));

	// Throttle path
	localparam int THR_SCALE = 255;
	localparam int PCT_W     = 7;
	localparam int K_W       = FRAC_BITS + FLD_W;
	localparam int MK_W      = MAG_W + K_W;
	localparam int NUM_W     = MK_W + PCT_W;
	localparam int THR_SH    = 2 * FRAC_BITS - 15;
	localparam int THR_DIV   = 25500;
	localparam int THR_HALF  = THR_DIV / 2;
	localparam int V_W       = NUM_W - THR_SH;
	localparam int THR_K     = 46;
	localparam logic [31:0] THR_R =
		32'(((64'd1 << THR_K) + 64'(THR_DIV) - 64'd1) / 64'(THR_DIV));

	// Result formats
	localparam int OUT_W = 16;
	localparam int RES_W = 20;

	// Config port
	localparam int CFG_W  = 40;
	localparam int ADDR_W = 3;
	localparam int OP_W   = 2;

	// Derived constants
	localparam logic [Q_W-1:0]     ONE_Q    = Q_W'(1) << QF;
	localparam logic [2*Q_W-1:0]   SQ_RND   = (2*Q_W)'(1) << (QF - 1);
	localparam logic [P5_W-1:0]    OUT_RND  = P5_W'(1) << (RND_SH - 1);
	localparam logic [MAG_W-1:0]   THR_FULL = MAG_W'(1) << FRAC_BITS;
	localparam logic [K_W:0]       THR_K255 = (K_W + 1)'(THR_SCALE) << FRAC_BITS;
	localparam logic [NUM_W-1:0]   THR_RND  = NUM_W'(THR_HALF) << THR_SH;
	localparam logic [RES_W-1:0]   SAT_POS  = RES_W'((2 ** (OUT_W - 1)) - 1);
	localparam logic [RES_W-1:0]   SAT_NEG  = RES_W'(2 ** (OUT_W - 1));

	// Reset values
	localparam logic [CFG_W-1:0] AXIS_RESET      = 40'h07D0000064;
	localparam logic [FLD_W-1:0] THR_CURVE_RESET = 8'd0;
	localparam logic [PCT_W-1:0] THR_PCT_RESET   = 7'd100;

	// Cycles from the accept edge to the result edge
	localparam int PIPE_LAT = 10;

	typedef enum logic [OP_W-1:0] {
		OP_ROLL,
		OP_PITCH,
		OP_YAW,
		OP_THROTTLE
	} op_t;

	typedef enum logic [ADDR_W-1:0] {
		REG_ROLL,
		REG_PITCH,
		REG_YAW,
		REG_THR_CURVE,
		REG_THR_PCT
	} reg_idx_t;

	typedef struct packed {
		logic [2:0][CFG_W-1:0] rate_set;
		logic [FLD_W-1:0]      thr_curve;
		logic [PCT_W-1:0]      thr_pct;
	} cfg_t;

	typedef struct packed {
		logic             vld;
		logic             neg;
		logic             use_lim;
		logic [RES_W-1:0] mag;
		logic [RES_W-1:0] lim;
	} res_t;

endpackage

@@ rtl/core/stick_rate_expo_shaper.sv @@
// Throughput: one item per cycle; busy stays low, and the multiply chain of the
// axis path (squares, expo divide, curve product, rounding) is fully pipelined.
// The receiver cannot stall: each result beat shows for exactly one cycle.
// Reset clears every valid bit and loads the register defaults; nothing in flight
// survives it.
// ----------------------------------------------------------------------------
// stick_rate_expo_shaper
// Stick-to-setpoint shaper: expo rate curve for roll, pitch and yaw, and a
// throttle curve, selected per item by op.
// ----------------------------------------------------------------------------
`include "stick_rate_expo_shaper_macros.svh"

module stick_rate_expo_shaper (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [srx_pkg::OP_W-1:0]              op,
	input  logic signed [srx_pkg::STICK_BITS-1:0] stick,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [srx_pkg::ADDR_W-1:0]            cfg_addr,
	input  logic [srx_pkg::CFG_W-1:0]             cfg_data,
	output logic                                  done,
	output logic signed [srx_pkg::OUT_W-1:0]      shaped_value,
	output logic                                  was_clamped
);

	srx_pkg::cfg_t cfg;
	srx_pkg::res_t axis_res;
	srx_pkg::res_t thr_res;
	logic          accept;
	logic          is_thr;

	// Always open to new items and register beats
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign is_thr    = (op == srx_pkg::OP_THROTTLE);

	srx_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_valid && cfg_ready),
		.addr   (cfg_addr),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	srx_axis u_axis (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (accept && !is_thr),
		.op     (op),
		.stick  (stick),
		.cfg    (cfg),
		.res    (axis_res)
	);

	srx_thr u_thr (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (accept && is_thr),
		.stick  (stick),
		.cfg    (cfg),
		.res    (thr_res)
	);

	srx_pack u_pack (
		.clk          (clk),
		.arst_n       (arst_n),
		.axis_res     (axis_res),
		.thr_res      (thr_res),
		.done         (done),
		.shaped_value (shaped_value),
		.was_clamped  (was_clamped)
	);

	// Checks
	`SRX_ASSERT_IMP(a_item_done, accept, ##(srx_pkg::PIPE_LAT) done, "item gave no result")
	`SRX_ASSERT_IMP(a_done_src, done, $past(accept, srx_pkg::PIPE_LAT), "result without item")
	`SRX_ASSERT(a_one_path, $onehot0({axis_res.vld, thr_res.vld}), "both paths live")
	`SRX_ASSERT_IMP(a_clamp_beat, was_clamped, done, "clamp flag outside a result beat")

endmodule

@@ rtl/core/srx_cfg.sv @@
// ----------------------------------------------------------------------------
// srx_cfg
// Configuration register file: three axis rate sets, the throttle curve and the throttle percent.
// ----------------------------------------------------------------------------
module srx_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr,
	input  logic [srx_pkg::ADDR_W-1:0] addr,
	input  logic [srx_pkg::CFG_W-1:0]  data,
	output srx_pkg::cfg_t              cfg
);

	srx_pkg::cfg_t cfg_q;

	// Take a register beat; drop writes past the last register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_set  <= {3{srx_pkg::AXIS_RESET}};
			cfg_q.thr_curve <= srx_pkg::THR_CURVE_RESET;
			cfg_q.thr_pct   <= srx_pkg::THR_PCT_RESET;
		end else if (wr) begin
			case (addr)
				srx_pkg::REG_ROLL:      cfg_q.rate_set[srx_pkg::OP_ROLL]  <= data;
				srx_pkg::REG_PITCH:     cfg_q.rate_set[srx_pkg::OP_PITCH] <= data;
				srx_pkg::REG_YAW:       cfg_q.rate_set[srx_pkg::OP_YAW]   <= data;
				srx_pkg::REG_THR_CURVE: cfg_q.thr_curve <= data[srx_pkg::FLD_W-1:0];
				srx_pkg::REG_THR_PCT:   cfg_q.thr_pct   <= data[srx_pkg::PCT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/srx_axis.sv @@
// ----------------------------------------------------------------------------
// srx_axis
// Nine-stage roll/pitch/yaw rate curve: squares, expo term, scaled sum and
// rounding to 1/16 deg/s. Produces sign, magnitude and the axis rate limit.
// ----------------------------------------------------------------------------
module srx_axis (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_vld,
	input  logic [srx_pkg::OP_W-1:0]       op,
	input  logic signed [srx_pkg::STICK_BITS-1:0] stick,
	input  srx_pkg::cfg_t                  cfg,
	output srx_pkg::res_t                  res
);

	// Entry: select the axis set and split it into fields
	logic [srx_pkg::CFG_W-1:0]      set_sel;
	logic [srx_pkg::STICK_BITS-1:0] stick_u;
	logic [srx_pkg::MAG_W-1:0]      mag_in;
	logic [srx_pkg::FLD_W-1:0]      c_in;
	logic [srx_pkg::FLD_W-1:0]      m_in;

	always_comb begin
		case (op)
			srx_pkg::OP_ROLL:  set_sel = cfg.rate_set[srx_pkg::OP_ROLL];
			srx_pkg::OP_PITCH: set_sel = cfg.rate_set[srx_pkg::OP_PITCH];
			srx_pkg::OP_YAW:   set_sel = cfg.rate_set[srx_pkg::OP_YAW];
			default:           set_sel = cfg.rate_set[srx_pkg::OP_ROLL];
		endcase
	end

	assign stick_u = stick;
	assign mag_in  = stick_u[srx_pkg::STICK_BITS-1] ? (~stick_u + 1'b1) : stick_u;
	assign c_in    = set_sel[7:0];
	assign m_in    = set_sel[23:16];

	// Valid chain
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// Payload carried along the chain
	logic sgn_s1, sgn_s2, sgn_s3, sgn_s4, sgn_s5, sgn_s6, sgn_s7;
	logic [srx_pkg::RES_W-1:0] lim_s1, lim_s2, lim_s3, lim_s4, lim_s5, lim_s6, lim_s7;
	logic [srx_pkg::RES_W-1:0] lim_s8, lim_s9;
	logic [srx_pkg::FLD_W-1:0] e_s1, e_s2, e_s3;
	logic [srx_pkg::FLD_W-1:0] c_s1, d_s1, d_s2;
	logic [srx_pkg::Q_W-1:0]   a_s1, sq_s2, q4_s3;
	logic [srx_pkg::AC_W-1:0]  ac_s2, ac_s3, ac_s4, ac_s5, ac_s6;
	logic [srx_pkg::SQD_W-1:0] sqd_s3, sqd_s4, sqd_s5;
	logic [srx_pkg::N_W-1:0]   n_s4;
	logic [srx_pkg::EM_W-1:0]  em_s5;
	logic signed [srx_pkg::U_W-1:0] prod_s6, u_s7;
	logic                      neg_s8, neg_s9;
	logic [srx_pkg::UM_W-1:0]  umag_s8;
	logic [srx_pkg::RES_W-1:0] r_s9;

	// Stage arithmetic
	logic [2*srx_pkg::Q_W-1:0]  aa, ss;
	logic [srx_pkg::Q_W-1:0]    one_m;
	logic [srx_pkg::N_W+31:0]   nr;
	logic signed [srx_pkg::G_W-1:0] g;
	logic signed [srx_pkg::SQD_W+srx_pkg::G_W:0] prod_full;
	logic signed [srx_pkg::U_W-1:0] ac_sh;
	logic [srx_pkg::P5_W-1:0]   p5;

	assign aa        = (2*srx_pkg::Q_W)'(a_s1) * (2*srx_pkg::Q_W)'(a_s1);
	assign ss        = (2*srx_pkg::Q_W)'(sq_s2) * (2*srx_pkg::Q_W)'(sq_s2);
	assign one_m     = srx_pkg::ONE_Q - q4_s3;
	assign nr        = (srx_pkg::N_W+32)'(n_s4) * (srx_pkg::N_W+32)'(srx_pkg::DIV100_R);
	assign g         = $signed(srx_pkg::G_W'(srx_pkg::ONE_Q) - srx_pkg::G_W'(em_s5));
	assign prod_full = $signed({1'b0, sqd_s5}) * g;
	assign ac_sh     = $signed(srx_pkg::U_W'(ac_s6) << srx_pkg::QF);
	assign p5        = srx_pkg::P5_W'(umag_s8) + (srx_pkg::P5_W'(umag_s8) << 2)
		+ srx_pkg::OUT_RND;

	// Advance the payload every cycle
	always_ff @(posedge clk) begin
		// s1: magnitude in Q24, axis fields
		sgn_s1 <= stick_u[srx_pkg::STICK_BITS-1];
		a_s1   <= srx_pkg::Q_W'(mag_in) << srx_pkg::A_SHIFT;
		c_s1   <= c_in;
		e_s1   <= set_sel[15:8];
		d_s1   <= (m_in > c_in) ? (m_in - c_in) : '0;
		lim_s1 <= srx_pkg::RES_W'({set_sel[39:24], 4'b0000});

		// s2: square and center term
		sq_s2  <= srx_pkg::Q_W'((aa + srx_pkg::SQ_RND) >> srx_pkg::QF);
		ac_s2  <= srx_pkg::AC_W'(a_s1) * srx_pkg::AC_W'(c_s1);
		sgn_s2 <= sgn_s1;
		e_s2   <= e_s1;
		d_s2   <= d_s1;
		lim_s2 <= lim_s1;

		// s3: fourth power and square times span
		q4_s3  <= srx_pkg::Q_W'((ss + srx_pkg::SQ_RND) >> srx_pkg::QF);
		sqd_s3 <= srx_pkg::SQD_W'(sq_s2) * srx_pkg::SQD_W'(d_s2);
		ac_s3  <= ac_s2;
		sgn_s3 <= sgn_s2;
		e_s3   <= e_s2;
		lim_s3 <= lim_s2;

		// s4: expo numerator with half-up bias
		n_s4   <= srx_pkg::N_W'(e_s3) * srx_pkg::N_W'(one_m)
			+ srx_pkg::N_W'(srx_pkg::EM_BIAS);
		sqd_s4 <= sqd_s3;
		ac_s4  <= ac_s3;
		sgn_s4 <= sgn_s3;
		lim_s4 <= lim_s3;

		// s5: divide by 100 through the reciprocal
		em_s5  <= srx_pkg::EM_W'(nr >> srx_pkg::DIV100_K);
		sqd_s5 <= sqd_s4;
		ac_s5  <= ac_s4;
		sgn_s5 <= sgn_s4;
		lim_s5 <= lim_s4;

		// s6: curve term
		prod_s6 <= srx_pkg::U_W'(prod_full);
		ac_s6   <= ac_s5;
		sgn_s6  <= sgn_s5;
		lim_s6  <= lim_s5;

		// s7: exact sum
		u_s7   <= ac_sh + prod_s6;
		sgn_s7 <= sgn_s6;
		lim_s7 <= lim_s6;

		// s8: sign and magnitude
		neg_s8  <= sgn_s7 ^ u_s7[srx_pkg::U_W-1];
		umag_s8 <= srx_pkg::UM_W'(u_s7[srx_pkg::U_W-1] ? -u_s7 : u_s7);
		lim_s8  <= lim_s7;

		// s9: scale by 160 and round to 1/16 deg/s
		r_s9   <= srx_pkg::RES_W'(p5 >> srx_pkg::RND_SH);
		neg_s9 <= neg_s8;
		lim_s9 <= lim_s8;
	end

	assign res.vld     = vld_s9;
	assign res.neg     = neg_s9;
	assign res.use_lim = 1'b1;
	assign res.mag     = r_s9;
	assign res.lim     = lim_s9;

endmodule

@@ rtl/core/srx_thr.sv @@
// ----------------------------------------------------------------------------
// srx_thr
// Throttle curve x*(1-a/255*(1-|x|))*pct/100, rounded to Q1.15. Nine stages so
// that it lines up with the axis path.
// ----------------------------------------------------------------------------
module srx_thr (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_vld,
	input  logic signed [srx_pkg::STICK_BITS-1:0] stick,
	input  srx_pkg::cfg_t                  cfg,
	output srx_pkg::res_t                  res
);

	logic [srx_pkg::STICK_BITS-1:0] stick_u;
	logic [srx_pkg::MAG_W-1:0]      mag_in;

	assign stick_u = stick;
	assign mag_in  = stick_u[srx_pkg::STICK_BITS-1] ? (~stick_u + 1'b1) : stick_u;

	// Valid chain
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	logic sgn_s1, sgn_s2, sgn_s3, sgn_s4, sgn_s5, sgn_s6, sgn_s7, sgn_s8, sgn_s9;
	logic [srx_pkg::MAG_W-1:0] mag_s1, mag_s2;
	logic [srx_pkg::K_W-1:0]   k_s2;
	logic [srx_pkg::MK_W-1:0]  mk_s3;
	logic [srx_pkg::V_W-1:0]   v_s4;
	logic [srx_pkg::RES_W-1:0] r_s5, r_s6, r_s7, r_s8, r_s9;

	logic [srx_pkg::K_W:0]       ak;
	logic [srx_pkg::NUM_W-1:0]   t;
	logic [srx_pkg::V_W+31:0]    vr;

	assign ak = (srx_pkg::K_W+1)'(cfg.thr_curve)
		* (srx_pkg::K_W+1)'(srx_pkg::THR_FULL - mag_s1);
	assign t  = srx_pkg::NUM_W'(mk_s3) * srx_pkg::NUM_W'(cfg.thr_pct) + srx_pkg::THR_RND;
	assign vr = (srx_pkg::V_W+32)'(v_s4) * (srx_pkg::V_W+32)'(srx_pkg::THR_R);

	// Advance the payload every cycle
	always_ff @(posedge clk) begin
		// s1: magnitude
		sgn_s1 <= stick_u[srx_pkg::STICK_BITS-1];
		mag_s1 <= mag_in;

		// s2: curve factor 255*full - a*(full-|x|)
		k_s2   <= srx_pkg::K_W'(srx_pkg::THR_K255 - ak);
		mag_s2 <= mag_s1;
		sgn_s2 <= sgn_s1;

		// s3: magnitude times curve factor
		mk_s3  <= srx_pkg::MK_W'(mag_s2) * srx_pkg::MK_W'(k_s2);
		sgn_s3 <= sgn_s2;

		// s4: apply percent, add half divisor, drop exact low bits
		v_s4   <= srx_pkg::V_W'(t >> srx_pkg::THR_SH);
		sgn_s4 <= sgn_s3;

		// s5: divide by 25500 through the reciprocal
		r_s5   <= srx_pkg::RES_W'(vr >> srx_pkg::THR_K);
		sgn_s5 <= sgn_s4;

		// s6..s9: hold alignment with the axis path
		r_s6   <= r_s5;
		r_s7   <= r_s6;
		r_s8   <= r_s7;
		r_s9   <= r_s8;
		sgn_s6 <= sgn_s5;
		sgn_s7 <= sgn_s6;
		sgn_s8 <= sgn_s7;
		sgn_s9 <= sgn_s8;
	end

	assign res.vld     = vld_s9;
	assign res.neg     = sgn_s9;
	assign res.use_lim = 1'b0;
	assign res.mag     = r_s9;
	assign res.lim     = '0;

endmodule

@@ rtl/core/srx_pack.sv @@
// ----------------------------------------------------------------------------
// srx_pack
// Final stage: pick the live path, clamp to the rate limit, saturate to
// 16 bits and register the result beat.
// ----------------------------------------------------------------------------
module srx_pack (
	input  logic                             clk,
	input  logic                             arst_n,
	input  srx_pkg::res_t                    axis_res,
	input  srx_pkg::res_t                    thr_res,
	output logic                             done,
	output logic signed [srx_pkg::OUT_W-1:0] shaped_value,
	output logic                             was_clamped
);

	srx_pkg::res_t             sel;
	logic                      vld;
	logic                      over_lim;
	logic [srx_pkg::RES_W-1:0] m1;
	logic                      neg;
	logic                      sat;
	logic [srx_pkg::RES_W-1:0] m2;
	logic [srx_pkg::OUT_W-1:0] val;

	// Pick the path, clamp, then saturate
	always_comb begin
		sel      = axis_res.vld ? axis_res : thr_res;
		vld      = axis_res.vld | thr_res.vld;
		over_lim = sel.use_lim && (sel.mag > sel.lim);
		m1       = over_lim ? sel.lim : sel.mag;
		neg      = sel.neg && (m1 != '0);
		sat      = neg ? (m1 > srx_pkg::SAT_NEG) : (m1 > srx_pkg::SAT_POS);
		m2       = sat ? (neg ? srx_pkg::SAT_NEG : srx_pkg::SAT_POS) : m1;
		val      = neg ? srx_pkg::OUT_W'(~m2 + 1'b1) : srx_pkg::OUT_W'(m2);
	end

	logic                      done_s10;
	logic                      clamped_s10;
	logic [srx_pkg::OUT_W-1:0] value_s10;

	// Result strobe and flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s10    <= 1'b0;
			clamped_s10 <= 1'b0;
		end else begin
			done_s10    <= vld;
			clamped_s10 <= vld && (over_lim || sat);
		end
	end

	// Result value
	always_ff @(posedge clk) begin
		value_s10 <= val;
	end

	assign done         = done_s10;
	assign was_clamped  = clamped_s10;
	assign shaped_value = $signed(value_s10);

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stick rate expo shaper. A short table of
// hand-picked sticks and register settings runs first, then random phases
// with fresh register settings and varied start gaps. Each result beat is
// checked against a bit-exact model of the rate and throttle curves.
// ----------------------------------------------------------------------------
module tb_top;
	import srx_pkg::*;

	localparam int FB          = STICK_BITS - 1;
	localparam int IDLE_LIMIT  = 2000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 88;
	localparam int LAST_ADDR   = (1 << ADDR_W) - 1;

	localparam logic [ADDR_W-1:0] REG_VOID = ADDR_W'(LAST_ADDR);

	localparam longint unsigned Q_ONE        = 64'd1 << 24;
	localparam longint unsigned Q_HALF       = 64'd1 << 23;
	localparam longint unsigned OUT_HALF     = 64'd1 << 42;
	localparam longint unsigned WORD_POS_MAX = (64'd1 << (OUT_W - 1)) - 1;
	localparam longint unsigned WORD_NEG_MAX = 64'd1 << (OUT_W - 1);

	localparam logic signed [STICK_BITS-1:0] STICK_MIN = {1'b1, {FB{1'b0}}};
	localparam logic signed [STICK_BITS-1:0] STICK_MAX = {1'b0, {FB{1'b1}}};

	typedef struct packed {
		logic signed [OUT_W-1:0] value;
		logic                    clamped;
	} shaped_t;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                     kind;
		logic [ADDR_W-1:0]             addr;
		logic [CFG_W-1:0]              data;
		op_t                           op;
		logic signed [STICK_BITS-1:0]  stick;
		bit                            known;
		shaped_t                       want;
	} row_t;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         start     = 1'b0;
	logic [OP_W-1:0]              op        = '0;
	logic signed [STICK_BITS-1:0] stick     = '0;
	logic                         cfg_valid = 1'b0;
	logic [ADDR_W-1:0]            cfg_addr  = '0;
	logic [CFG_W-1:0]             cfg_data  = '0;
	logic                         busy;
	logic                         cfg_ready;
	logic                         done;
	logic signed [OUT_W-1:0]      shaped_value;
	logic                         was_clamped;

	// Register copies used for prediction
	logic [CFG_W-1:0] roll_set      = AXIS_RESET;
	logic [CFG_W-1:0] pitch_set     = AXIS_RESET;
	logic [CFG_W-1:0] yaw_set       = AXIS_RESET;
	logic [FLD_W-1:0] thr_curve_set = THR_CURVE_RESET;
	logic [PCT_W-1:0] throttle_pct  = THR_PCT_RESET;

	shaped_t shapes_due[$];
	shaped_t due_shape;
	row_t    plan[$];
	int      mismatches   = 0;
	int      quiet_cycles = 0;
	int      idle_pct     = 0;

	stick_rate_expo_shaper DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.stick        (stick),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.done         (done),
		.shaped_value (shaped_value),
		.was_clamped  (was_clamped)
	);

	always #2 clk = ~clk;

	// Saturate a sign and magnitude to the 16-bit result word
	function automatic shaped_t clip_to_word(bit neg, longint unsigned mag, bit clamped);
		shaped_t w;
		if (!neg && mag > WORD_POS_MAX) begin
			mag = WORD_POS_MAX;
			clamped = 1'b1;
		end
		if (neg && mag > WORD_NEG_MAX) begin
			mag = WORD_NEG_MAX;
			clamped = 1'b1;
		end
		w.value = neg ? OUT_W'(64'd0 - mag) : OUT_W'(mag);
		w.clamped = clamped;
		return w;
	endfunction

	// Axis rate: linear center part plus expo curve on the rate above center,
	// scaled to 1/16 deg/s and held to the axis limit
	function automatic shaped_t rate_curve(logic [CFG_W-1:0] set,
			logic signed [STICK_BITS-1:0] s);
		longint unsigned ctr, ex, mx, lim, a, sq, q4, em, mag_u, r;
		longint stick_val, g, d, u;
		bit neg, clamped;
		ctr = 64'(set[7:0]);
		ex = 64'(set[15:8]);
		mx = 64'(set[23:16]);
		lim = longint'(set[39:24]) * 16;
		stick_val = longint'(s);
		a = ((stick_val < 0) ? -stick_val : stick_val) << (24 - FB);
		sq = (a * a + Q_HALF) >> 24;
		q4 = (sq * sq + Q_HALF) >> 24;
		em = (ex * (Q_ONE - q4) + 50) / 100;
		g = longint'(Q_ONE) - longint'(em);
		d = (mx > ctr) ? longint'(mx - ctr) : 0;
		u = longint'((a * ctr) << 24) + longint'(sq) * g * d;
		mag_u = (u < 0) ? -u : u;
		neg = (stick_val < 0) != (u < 0);
		r = (mag_u * 5 + OUT_HALF) >> 43;
		clamped = 1'b0;
		if (r > lim) begin
			r = lim;
			clamped = 1'b1;
		end
		if (r == 0)
			neg = 1'b0;
		return clip_to_word(neg, r, clamped);
	endfunction

	// Throttle: blend of linear and parabolic, then scaled by the ceiling percent
	function automatic shaped_t throttle_shape(logic signed [STICK_BITS-1:0] s);
		longint unsigned full, mag, k, num, den, r;
		longint stick_val;
		stick_val = longint'(s);
		full = 64'd1 << FB;
		mag = (stick_val < 0) ? -stick_val : stick_val;
		k = 255 * full - longint'(thr_curve_set) * (full - mag);
		num = mag * k * longint'(throttle_pct);
		den = 64'd25500 << (2 * FB - 15);
		r = (num + den / 2) / den;
		return clip_to_word(stick_val < 0 && r != 0, r, 1'b0);
	endfunction

	function automatic shaped_t predict_shape(op_t o, logic signed [STICK_BITS-1:0] s);
		case (o)
			OP_ROLL:  return rate_curve(roll_set, s);
			OP_PITCH: return rate_curve(pitch_set, s);
			OP_YAW:   return rate_curve(yaw_set, s);
			default:  return throttle_shape(s);
		endcase
	endfunction

	// Mirror a register write; unknown indexes are dropped
	function automatic void note_config(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
		case (addr)
			REG_ROLL:      roll_set = data;
			REG_PITCH:     pitch_set = data;
			REG_YAW:       yaw_set = data;
			REG_THR_CURVE: thr_curve_set = data[FLD_W-1:0];
			REG_THR_PCT:   throttle_pct = data[PCT_W-1:0];
			default: ;
		endcase
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		$display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Check each result beat against the oldest expected shape
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (shapes_due.size() == 0) begin
				flag_mismatch("result with nothing due", int'(shaped_value), 0);
			end else begin
				due_shape = shapes_due.pop_front();
				if (shaped_value !== due_shape.value)
					flag_mismatch("shaped_value", int'(shaped_value),
						int'(due_shape.value));
				if (was_clamped !== due_shape.clamped)
					flag_mismatch("was_clamped", int'(was_clamped),
						int'(due_shape.clamped));
			end
		end
	end

	// Watchdog: give up after a long stretch with no beat on any channel
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Drive one stick beat after a random gap; leaves start high on return
	task automatic send_item(op_t o, logic signed [STICK_BITS-1:0] s, bit known,
			shaped_t want);
		shaped_t due;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		op <= o;
		stick <= s;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		due = known ? want : predict_shape(o, s);
		@(negedge clk);
		shapes_due.push_back(due);
	endtask

	// Drive one register beat; leaves cfg_valid high on return
	task automatic write_reg(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		note_config(addr, data);
	endtask

	task automatic stop_sending();
		start <= 1'b0;
	endtask

	task automatic release_cfg();
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (shapes_due.size() != 0)
			@(negedge clk);
	endtask

	function automatic void add_item(op_t o, int s, bit known, int v, bit c);
		row_t row;
		row.kind = ROW_ITEM;
		row.addr = '0;
		row.data = '0;
		row.op = o;
		row.stick = STICK_BITS'(s);
		row.known = known;
		row.want.value = OUT_W'(v);
		row.want.clamped = c;
		plan.push_back(row);
	endfunction

	function automatic void add_cfg(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
		row_t row;
		row.kind = ROW_CFG;
		row.addr = addr;
		row.data = data;
		row.op = OP_ROLL;
		row.stick = '0;
		row.known = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endfunction

	// Directed table: corners of the stick, every path, each clamp case
	function automatic void build_plan();
		// reset settings: rate is 1000 * x deg/s, throttle passes through
		add_item(OP_ROLL, 0, 1, 0, 0);
		add_item(OP_ROLL, STICK_MAX, 1, 16000, 0);
		add_item(OP_ROLL, STICK_MIN, 1, -16000, 0);
		add_item(OP_PITCH, 16384, 0, 0, 0);
		add_item(OP_YAW, -1, 0, 0, 0);
		add_item(OP_THROTTLE, STICK_MAX, 1, STICK_MAX, 0);
		add_item(OP_THROTTLE, STICK_MIN, 1, STICK_MIN, 0);
		add_item(OP_THROTTLE, 0, 1, 0, 0);
		// all fields at max: result word saturates
		add_cfg(REG_ROLL, 40'hFF_FFFF_FFFF);
		add_item(OP_ROLL, STICK_MAX, 1, STICK_MAX, 1);
		add_item(OP_ROLL, STICK_MIN, 1, STICK_MIN, 1);
		// expo well above 100 percent bends the curve back
		add_cfg(REG_PITCH, 40'h07_D0FF_FF00);
		add_item(OP_PITCH, STICK_MAX, 0, 0, 0);
		add_item(OP_PITCH, STICK_MIN, 0, 0, 0);
		add_item(OP_PITCH, 16384, 0, 0, 0);
		add_item(OP_PITCH, -8192, 0, 0, 0);
		// zero rate limit: any nonzero rate clamps to zero
		add_cfg(REG_YAW, 40'h00_00C8_3264);
		add_item(OP_YAW, STICK_MAX, 1, 0, 1);
		add_item(OP_YAW, 0, 1, 0, 0);
		// parabolic throttle above 100 percent saturates
		add_cfg(REG_THR_CURVE, 40'd255);
		add_cfg(REG_THR_PCT, 40'd127);
		add_item(OP_THROTTLE, STICK_MAX, 1, STICK_MAX, 1);
		add_item(OP_THROTTLE, STICK_MIN, 1, STICK_MIN, 1);
		add_item(OP_THROTTLE, 16384, 0, 0, 0);
		add_cfg(REG_THR_PCT, 40'd0);
		add_item(OP_THROTTLE, STICK_MAX, 1, 0, 0);
		add_item(OP_THROTTLE, STICK_MIN, 1, 0, 0);
		// unknown index must leave every register alone
		add_cfg(REG_VOID, '1);
		add_item(OP_THROTTLE, STICK_MAX, 1, 0, 0);
		// bits above the register width are dropped
		add_cfg(REG_THR_CURVE, 40'hFF_FFFF_FF00);
		add_cfg(REG_THR_PCT, 40'hFF_FFFF_FF64);
		add_item(OP_THROTTLE, STICK_MAX, 1, STICK_MAX, 0);
		add_item(OP_THROTTLE, STICK_MIN, 1, STICK_MIN, 0);
	endfunction

	function automatic logic [CFG_W-1:0] rand_rate_set();
		logic [LIMF_W-1:0] lim;
		logic [FLD_W-1:0]  ctr, ex, mx;
		ctr = FLD_W'($urandom_range(0, 255));
		ex = ($urandom_range(0, 3) == 0) ? FLD_W'($urandom_range(0, 255))
			: FLD_W'($urandom_range(0, 100));
		mx = FLD_W'($urandom_range(0, 255));
		case ($urandom_range(0, 4))
			0:       lim = LIMF_W'($urandom);
			1:       lim = LIMF_W'($urandom_range(0, 50));
			2:       lim = LIMF_W'(2000);
			default: lim = LIMF_W'($urandom_range(100, 2000));
		endcase
		if ($urandom_range(0, 4) == 0)
			return CFG_W'({$urandom, $urandom});
		return {lim, mx, ex, ctr};
	endfunction

	// Second phase runs all zeros, last phase all ones, the rest random
	function automatic logic [CFG_W-1:0] phase_value(int p, logic [CFG_W-1:0] mid);
		if (p == 1)
			return '0;
		if (p == PHASES - 1)
			return '1;
		return mid;
	endfunction

	task automatic load_phase_config(int p);
		logic [CFG_W-1:0] pct;
		pct = ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(0, 100))
			: CFG_W'({$urandom, $urandom});
		write_reg(REG_ROLL, phase_value(p, rand_rate_set()));
		write_reg(REG_PITCH, phase_value(p, rand_rate_set()));
		write_reg(REG_YAW, phase_value(p, rand_rate_set()));
		write_reg(REG_THR_CURVE, phase_value(p, CFG_W'({$urandom, $urandom})));
		write_reg(REG_THR_PCT, phase_value(p, pct));
		write_reg(ADDR_W'($urandom_range(REG_THR_PCT + 1, LAST_ADDR)),
			CFG_W'({$urandom, $urandom}));
		release_cfg();
	endtask

	function automatic logic signed [STICK_BITS-1:0] rand_stick();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0:       return STICK_MIN;
					1:       return STICK_MAX;
					2:       return '0;
					3:       return STICK_BITS'(1);
					default: return '1;
				endcase
			end
			1:       return STICK_BITS'(int'($urandom_range(0, 511)) - 256);
			default: return STICK_BITS'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		int p;
		int n;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// walk the directed table; registers change only once drained
		build_plan();
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				stop_sending();
				wait_drained();
				write_reg(plan[i].addr, plan[i].data);
			end else begin
				release_cfg();
				send_item(plan[i].op, plan[i].stick, plan[i].known, plan[i].want);
			end
		end

		// random phases; odd phases thin out start, even ones run back to back
		for (p = 0; p < PHASES; p++) begin
			stop_sending();
			wait_drained();
			load_phase_config(p);
			idle_pct = (p % 4 == 1) ? 56 : (p % 4 == 3) ? 37 : 0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// hold off once mid-phase until the pipe is empty
				if (p == 3 && n == PHASE_ITEMS / 2) begin
					stop_sending();
					wait_drained();
				end
				send_item(op_t'($urandom_range(0, 3)), rand_stick(), 1'b0, '0);
			end
		end

		stop_sending();
		wait_drained();
		repeat (PIPE_LAT + 4) @(negedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/srx_pkg.sv
rtl/core/srx_cfg.sv
rtl/core/srx_axis.sv
rtl/core/srx_thr.sv
rtl/core/srx_pack.sv
rtl/core/stick_rate_expo_shaper.sv
tb/sv/tb_top.sv
